[design/kvtu_pkg.sv]
// Package: shared widths, codes and control types for the keyed value table.
`timescale 1ns / 1ps
`default_nettype none
package kvtu_pkg;

   localparam int KEY_W            = 64;
   localparam int VALUE_W          = 64;
   localparam int ENTRY_W          = KEY_W + 1;
   localparam int OP_W             = 3;
   localparam int STATUS_W         = 2;
   localparam int COUNT_OUT_W      = 7;
   localparam int DEFAULT_CAPACITY = 64;

   typedef enum logic [OP_W-1:0] {
      OP_SET  = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_MIN  = 3'd5,
      OP_MAX  = 3'd6,
      OP_READ = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_KEY = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_CALC  = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_DONE  = 6'b100000
   } ctl_state_type;

   typedef enum logic [2:0] {
      A_IDLE = 3'b001,
      A_MUL  = 3'b010,
      A_DIV  = 3'b100
   } alu_state_type;

   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic val_we;
   } mem_cmd_type;

endpackage
`default_nettype wire

[design/kvtu_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface kvtu_req_if;
   logic                          valid;
   logic                          ready;
   logic [kvtu_pkg::KEY_W-1:0]    key;
   logic [kvtu_pkg::OP_W-1:0]     op;
   logic [kvtu_pkg::VALUE_W-1:0]  operand;

   modport source (output valid, key, op, operand, input ready);
   modport sink   (input valid, key, op, operand, output ready);
endinterface

interface kvtu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [kvtu_pkg::VALUE_W-1:0]      old_value;
   logic [kvtu_pkg::VALUE_W-1:0]      new_value;
   logic                              changed;
   logic [kvtu_pkg::STATUS_W-1:0]     status;
   logic [kvtu_pkg::COUNT_OUT_W-1:0]  entry_count;

   modport source (output valid, old_value, new_value, changed, status, entry_count,
                   input ready);
   modport sink   (input valid, old_value, new_value, changed, status, entry_count,
                   output ready);
endinterface
`default_nettype wire

[design/kvtu_alu.sv]
// Arithmetic unit: registered simple ops, 32x32 partial-product multiply, radix-2 divide.
`timescale 1ns / 1ps
`default_nettype none
module kvtu_alu (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire kvtu_pkg::op_type              op,
   input  wire logic [kvtu_pkg::VALUE_W-1:0]  cur,
   input  wire logic [kvtu_pkg::VALUE_W-1:0]  operand,
   output logic                               done,
   output logic [kvtu_pkg::VALUE_W-1:0]       result
);

   localparam int W  = kvtu_pkg::VALUE_W;
   localparam int HW = W / 2;

   kvtu_pkg::alu_state_type state_ff, state_in;
   logic [5:0]   step_ff, step_in;
   logic         done_ff, done_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [W-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [HW-1:0] mul_x, mul_y;
   logic [W:0]   rem_sh, diff;
   logic [W-1:0] simple;

   always_comb begin
      case (op)
         kvtu_pkg::OP_SET: simple = operand;
         kvtu_pkg::OP_ADD: simple = cur + operand;
         kvtu_pkg::OP_SUB: simple = (cur > operand) ? cur - operand : '0;
         kvtu_pkg::OP_MIN: simple = (cur < operand) ? cur : operand;
         kvtu_pkg::OP_MAX: simple = (cur > operand) ? cur : operand;
         default:          simple = cur;
      endcase
   end

   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            mul_x = a_ff[HW-1:0];
            mul_y = b_ff[HW-1:0];
         end
         2'd1: begin
            mul_x = a_ff[HW-1:0];
            mul_y = b_ff[W-1:HW];
         end
         default: begin
            mul_x = a_ff[W-1:HW];
            mul_y = b_ff[HW-1:0];
         end
      endcase
      prod_in = W'(mul_x) * W'(mul_y);
      rem_sh  = {rem_ff, quo_ff[W-1]};
      diff    = rem_sh - {1'b0, b_ff};
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      case (state_ff)
         kvtu_pkg::A_IDLE: begin
            if (start) begin
               a_in    = cur;
               b_in    = operand;
               step_in = '0;
               rem_in  = '0;
               quo_in  = cur;
               if (op == kvtu_pkg::OP_MUL) begin
                  state_in = kvtu_pkg::A_MUL;
               end else if (op == kvtu_pkg::OP_DIV && operand != '0) begin
                  state_in = kvtu_pkg::A_DIV;
               end else begin
                  res_in  = simple;
                  done_in = 1'b1;
               end
            end
         end
         kvtu_pkg::A_MUL: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd1) begin
               acc_in = prod_ff;
            end else if (step_ff != 6'd0) begin
               acc_in = {acc_ff[W-1:HW] + prod_ff[HW-1:0], acc_ff[HW-1:0]};
            end
            if (step_ff == 6'd3) begin
               res_in   = acc_in;
               done_in  = 1'b1;
               state_in = kvtu_pkg::A_IDLE;
            end
         end
         kvtu_pkg::A_DIV: begin
            step_in = step_ff + 6'd1;
            if (!diff[W]) begin
               rem_in = diff[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            if (step_ff == 6'd63) begin
               res_in   = quo_in;
               done_in  = 1'b1;
               state_in = kvtu_pkg::A_IDLE;
            end
         end
         default: state_in = kvtu_pkg::A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kvtu_pkg::A_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef SYNTH
   a_done_source: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(start) || $past(state_ff != kvtu_pkg::A_IDLE)))
      else $error("alu done without work");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == kvtu_pkg::A_IDLE))
      else $error("alu started while busy");
`endif

endmodule
`default_nettype wire

[design/kvtu_store.sv]
// Entry store: key/valid memory and value memory, shared read address, clear sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module kvtu_store #(
   parameter int CAPACITY = kvtu_pkg::DEFAULT_CAPACITY,
   localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire kvtu_pkg::mem_cmd_type         cmd,
   input  wire logic [IW-1:0]                 rd_addr,
   input  wire logic [IW-1:0]                 wr_addr,
   input  wire logic [kvtu_pkg::ENTRY_W-1:0]  wr_key_word,
   input  wire logic [kvtu_pkg::VALUE_W-1:0]  wr_value,
   output logic [kvtu_pkg::ENTRY_W-1:0]       rd_key_word,
   output logic [kvtu_pkg::VALUE_W-1:0]       rd_value,
   output logic                               busy
);

   logic [kvtu_pkg::ENTRY_W-1:0] key_mem [CAPACITY];
   logic [kvtu_pkg::VALUE_W-1:0] value_mem [CAPACITY];
   logic [kvtu_pkg::ENTRY_W-1:0] key_rd_ff;
   logic [kvtu_pkg::VALUE_W-1:0] value_rd_ff;
   logic                         clr_ff, clr_in;
   logic [IW-1:0]                clr_addr_ff, clr_addr_in;
   logic                         key_we;
   logic [IW-1:0]                key_wa;
   logic [kvtu_pkg::ENTRY_W-1:0] key_wd;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IW'(CAPACITY - 1)) begin
            clr_in = 1'b0;
         end
      end
      key_we = clr_ff || cmd.key_we;
      key_wa = clr_ff ? clr_addr_ff : wr_addr;
      key_wd = clr_ff ? '0 : wr_key_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= key_wd;
      end
      if (cmd.rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.val_we) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (cmd.rd_en) begin
         value_rd_ff <= value_mem[rd_addr];
      end
   end

   assign rd_key_word = key_rd_ff;
   assign rd_value    = value_rd_ff;
   assign busy        = clr_ff;

`ifndef SYNTH
   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !(cmd.rd_en || cmd.key_we || cmd.val_we))
      else $error("store access during clear sweep");
`endif

endmodule
`default_nettype wire

[design/keyed_value_table_update.sv]
// Top level: keyed value table with lookup scan, arithmetic update and write-back.
// Flow from the accepting edge to rsp_bus.valid: a zero key goes straight to the done state;
//   otherwise a scan (one entry per cycle, stops at a hit), then the ALU op (simple,
//   multiply or divide), then write-back and done; done waits while a beat is held.
// Throughput: one request at a time; req_bus.ready rises with the posted response beat.
// Reset: synchronous; a clear sweep then writes every key slot invalid,
//   during which req_bus.ready is low.
`timescale 1ns / 1ps
`default_nettype none
module keyed_value_table_update #(
   parameter int CAPACITY = kvtu_pkg::DEFAULT_CAPACITY
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kvtu_req_if.sink   req_bus,
   kvtu_rsp_if.source rsp_bus
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int W  = kvtu_pkg::VALUE_W;

   kvtu_pkg::ctl_state_type state_ff, state_in;
   kvtu_pkg::op_type        op_ff;
   logic [kvtu_pkg::KEY_W-1:0] key_ff;
   logic [W-1:0]            operand_ff;
   logic [IW:0]             iss_ff, iss_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                    hit_ff, hit_in;
   logic [IW-1:0]           hit_idx_ff, hit_idx_in;
   logic                    free_vld_ff, free_vld_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;
   logic [W-1:0]            cur_ff, cur_in, res_ff, res_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW+6:0]           count_ext;
   logic [W-1:0]            pend_old_ff, pend_old_in, pend_new_ff, pend_new_in;
   logic                    pend_chg_ff, pend_chg_in;
   kvtu_pkg::status_type    pend_st_ff, pend_st_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [W-1:0]            rsp_old_ff, rsp_old_in, rsp_new_ff, rsp_new_in;
   logic                    rsp_chg_ff, rsp_chg_in;
   kvtu_pkg::status_type    rsp_st_ff, rsp_st_in;
   logic [kvtu_pkg::COUNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   kvtu_pkg::mem_cmd_type   cmd;
   logic [IW-1:0]           wr_addr;
   logic [kvtu_pkg::ENTRY_W-1:0] rd_key_word, wr_key_word;
   logic [W-1:0]            rd_value;
   logic                    store_busy;
   logic                    accept;
   logic                    alu_start, alu_done;
   logic [W-1:0]            alu_res;

   kvtu_store #(.CAPACITY(CAPACITY)) u_store (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_addr     (iss_ff[IW-1:0]),
      .wr_addr     (wr_addr),
      .wr_key_word (wr_key_word),
      .wr_value    (res_ff),
      .rd_key_word (rd_key_word),
      .rd_value    (rd_value),
      .busy        (store_busy)
   );

   kvtu_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .start   (alu_start),
      .op      (op_ff),
      .cur     (cur_ff),
      .operand (operand_ff),
      .done    (alu_done),
      .result  (alu_res)
   );

   assign req_bus.ready = (state_ff == kvtu_pkg::ST_IDLE) && !store_busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign count_ext     = {7'd0, count_ff};
   assign wr_addr       = hit_ff ? hit_idx_ff : free_idx_ff;
   assign wr_key_word   = {!hit_ff, key_ff};

   always_comb begin
      state_in    = state_ff;
      iss_in      = iss_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      cur_in      = cur_ff;
      res_in      = res_ff;
      count_in    = count_ff;
      pend_old_in = pend_old_ff;
      pend_new_in = pend_new_ff;
      pend_chg_in = pend_chg_ff;
      pend_st_in  = pend_st_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_bus.ready;
      rsp_old_in  = rsp_old_ff;
      rsp_new_in  = rsp_new_ff;
      rsp_chg_in  = rsp_chg_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      cmd         = '0;
      alu_start   = 1'b0;
      case (state_ff)
         kvtu_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_bus.key == '0) begin
                  pend_old_in = '0;
                  pend_new_in = '0;
                  pend_chg_in = 1'b0;
                  pend_st_in  = kvtu_pkg::STATUS_ZERO_KEY;
                  state_in    = kvtu_pkg::ST_DONE;
               end else begin
                  iss_in      = '0;
                  hit_in      = 1'b0;
                  free_vld_in = 1'b0;
                  state_in    = kvtu_pkg::ST_SCAN;
               end
            end
         end
         kvtu_pkg::ST_SCAN: begin
            if (iss_ff != (IW + 1)'(CAPACITY)) begin
               cmd.rd_en  = 1'b1;
               iss_in     = iss_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[IW-1:0];
            end
            if (cmp_vld_ff) begin
               if (rd_key_word[kvtu_pkg::KEY_W] && rd_key_word[kvtu_pkg::KEY_W-1:0] == key_ff)
               begin
                  hit_in     = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  cur_in     = rd_value;
                  cmp_vld_in = 1'b0;
                  state_in   = kvtu_pkg::ST_CALC;
               end else begin
                  if (!rd_key_word[kvtu_pkg::KEY_W] && !free_vld_ff) begin
                     free_vld_in = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == IW'(CAPACITY - 1)) begin
                     cur_in     = '0;
                     cmp_vld_in = 1'b0;
                     state_in   = kvtu_pkg::ST_CALC;
                  end
               end
            end
         end
         kvtu_pkg::ST_CALC: begin
            alu_start = 1'b1;
            state_in  = kvtu_pkg::ST_EXEC;
         end
         kvtu_pkg::ST_EXEC: begin
            if (alu_done) begin
               res_in   = alu_res;
               state_in = kvtu_pkg::ST_WRITE;
            end
         end
         kvtu_pkg::ST_WRITE: begin
            pend_st_in = kvtu_pkg::STATUS_OK;
            if (res_ff == '0) begin
               pend_new_in = '0;
               if (hit_ff) begin
                  cmd.key_we  = 1'b1;
                  count_in    = count_ff - CW'(1);
                  pend_old_in = cur_ff;
                  pend_chg_in = 1'b1;
               end else begin
                  pend_old_in = '0;
                  pend_chg_in = 1'b0;
               end
            end else if (hit_ff) begin
               pend_old_in = cur_ff;
               pend_new_in = res_ff;
               pend_chg_in = (cur_ff != res_ff);
               cmd.val_we  = (cur_ff != res_ff);
            end else if (!free_vld_ff) begin
               pend_old_in = '0;
               pend_new_in = '0;
               pend_chg_in = 1'b0;
               pend_st_in  = kvtu_pkg::STATUS_FULL;
            end else begin
               cmd.key_we  = 1'b1;
               cmd.val_we  = 1'b1;
               count_in    = count_ff + CW'(1);
               pend_old_in = '0;
               pend_new_in = res_ff;
               pend_chg_in = 1'b1;
            end
            state_in = kvtu_pkg::ST_DONE;
         end
         kvtu_pkg::ST_DONE: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in = 1'b1;
               rsp_old_in = pend_old_ff;
               rsp_new_in = pend_new_ff;
               rsp_chg_in = pend_chg_ff;
               rsp_st_in  = pend_st_ff;
               rsp_cnt_in = count_ext[kvtu_pkg::COUNT_OUT_W-1:0];
               state_in   = kvtu_pkg::ST_IDLE;
            end
         end
         default: state_in = kvtu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= kvtu_pkg::ST_IDLE;
         cmp_vld_ff  <= 1'b0;
         hit_ff      <= 1'b0;
         free_vld_ff <= 1'b0;
         count_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         iss_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         cmp_vld_ff  <= cmp_vld_in;
         hit_ff      <= hit_in;
         free_vld_ff <= free_vld_in;
         count_ff    <= count_in;
         rsp_vld_ff  <= rsp_vld_in;
         iss_ff      <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff     <= req_bus.key;
         op_ff      <= kvtu_pkg::op_type'(req_bus.op);
         operand_ff <= req_bus.operand;
      end
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
      pend_old_ff <= pend_old_in;
      pend_new_ff <= pend_new_in;
      pend_chg_ff <= pend_chg_in;
      pend_st_ff  <= pend_st_in;
      rsp_old_ff  <= rsp_old_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.old_value   = rsp_old_ff;
   assign rsp_bus.new_value   = rsp_new_ff;
   assign rsp_bus.changed     = rsp_chg_ff;
   assign rsp_bus.status      = rsp_st_ff;
   assign rsp_bus.entry_count = rsp_cnt_ff;

`ifndef SYNTH
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !req_bus.ready)
      else $error("request taken during clear sweep");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.key_we || cmd.val_we) |-> (state_ff == kvtu_pkg::ST_WRITE))
      else $error("store write outside write-back");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == kvtu_pkg::ST_DONE))
      else $error("response beat not from done state");
`endif

endmodule
`default_nettype wire

[tb/sv/keyed_value_table_update_test.sv]
// Testbench for keyed_value_table_update: predicted table updates checked beat by beat.
`timescale 1ns / 1ps
module keyed_value_table_update_test;

   localparam int CAPACITY     = kvtu_pkg::DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 1700;
   localparam int POOL_SIZE    = CAPACITY + 8;
   localparam int PHASE_LEN    = 170;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 160;

   typedef struct {
      logic [kvtu_pkg::KEY_W-1:0]   key;
      kvtu_pkg::op_type             op;
      logic [kvtu_pkg::VALUE_W-1:0] operand;
      bit                           drain_first;
   } table_req_type;

   typedef struct packed {
      logic [kvtu_pkg::VALUE_W-1:0]     old_value;
      logic [kvtu_pkg::VALUE_W-1:0]     new_value;
      logic                             changed;
      logic [kvtu_pkg::STATUS_W-1:0]    status;
      logic [kvtu_pkg::COUNT_OUT_W-1:0] entry_count;
   } table_rsp_type;

   logic clock;
   logic reset;

   kvtu_req_if req_bus ();
   kvtu_rsp_if rsp_bus ();

   keyed_value_table_update #(.CAPACITY(CAPACITY)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted table contents
   logic [kvtu_pkg::KEY_W-1:0]   tbl_key [CAPACITY];
   logic [kvtu_pkg::VALUE_W-1:0] tbl_val [CAPACITY];
   bit                           tbl_used [CAPACITY];
   int                           tbl_count;

   table_req_type pending_q[$];
   table_rsp_type expected_q[$];
   table_req_type offered;

   logic [kvtu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

   int n_sent, n_results, n_mismatch;
   int n_inserts, n_erases, n_refused, n_zero_key, peak_count;
   int gap_left, stall_left, hold_left;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic table_rsp_type apply_request(input table_req_type r);
      table_rsp_type                res;
      int                           hit;
      int                           free_slot;
      logic [kvtu_pkg::VALUE_W-1:0] cur;
      logic [kvtu_pkg::VALUE_W-1:0] nv;
      res       = '0;
      hit       = -1;
      free_slot = -1;
      if (r.key == '0) begin
         n_zero_key++;
         res.status      = kvtu_pkg::STATUS_ZERO_KEY;
         res.entry_count = tbl_count[kvtu_pkg::COUNT_OUT_W-1:0];
         return res;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (tbl_used[i]) begin
            if (hit < 0 && tbl_key[i] == r.key) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      cur = (hit >= 0) ? tbl_val[hit] : '0;
      case (r.op)
         kvtu_pkg::OP_SET: nv = r.operand;
         kvtu_pkg::OP_ADD: nv = cur + r.operand;
         kvtu_pkg::OP_SUB: nv = (cur > r.operand) ? cur - r.operand : '0;
         kvtu_pkg::OP_MUL: nv = cur * r.operand;
         kvtu_pkg::OP_DIV: nv = (r.operand != '0) ? cur / r.operand : cur;
         kvtu_pkg::OP_MIN: nv = (cur < r.operand) ? cur : r.operand;
         kvtu_pkg::OP_MAX: nv = (cur > r.operand) ? cur : r.operand;
         default: nv = cur;
      endcase
      res.status = kvtu_pkg::STATUS_OK;
      if (nv == '0) begin
         if (hit >= 0) begin
            tbl_used[hit] = 1'b0;
            tbl_count--;
            n_erases++;
            res.old_value = cur;
            res.changed   = 1'b1;
         end
      end else if (hit >= 0) begin
         res.old_value = cur;
         res.new_value = nv;
         res.changed   = (tbl_val[hit] != nv);
         tbl_val[hit]  = nv;
      end else if (free_slot < 0) begin
         n_refused++;
         res.status = kvtu_pkg::STATUS_FULL;
      end else begin
         tbl_key[free_slot]  = r.key;
         tbl_val[free_slot]  = nv;
         tbl_used[free_slot] = 1'b1;
         tbl_count++;
         n_inserts++;
         if (tbl_count > peak_count) peak_count = tbl_count;
         res.new_value = nv;
         res.changed   = 1'b1;
      end
      res.entry_count = tbl_count[kvtu_pkg::COUNT_OUT_W-1:0];
      return res;
   endfunction

   // every third block of 128 beats runs with no idling on that side
   function automatic int pick_wait(input int beats);
      if ((beats / 128) % 3 == 2) return 0;
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 64'd1;
         2: return '1;
         3: return 64'h8000_0000_0000_0000;
         4, 5: return 64'($urandom_range(1, 16));
         6: return 64'($urandom_range(1, 1000));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_req(input logic [63:0] k, input kvtu_pkg::op_type op,
                          input logic [63:0] x, input bit drain);
      table_req_type r;
      r.key         = k;
      r.op          = op;
      r.operand     = x;
      r.drain_first = drain;
      pending_q.insert(pending_q.size(), r);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.key     <= '0;
         req_bus.op      <= kvtu_pkg::OP_READ;
         req_bus.operand <= '0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_q.insert(expected_q.size(), apply_request(offered));
            n_sent++;
            gap_left = pick_wait(n_sent);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && expected_q.size() != 0)) begin
               req_bus.valid <= 1'b0;
            end else begin
               offered = pending_q.pop_front();
               req_bus.key     <= offered.key;
               req_bus.op      <= offered.op;
               req_bus.operand <= offered.operand;
               req_bus.valid   <= 1'b1;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      table_rsp_type got;
      table_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.old_value, rsp_bus.new_value, rsp_bus.changed,
                   rsp_bus.status, rsp_bus.entry_count};
            n_results++;
            if (expected_q.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("ERROR: unexpected beat old=%h new=%h chg=%b st=%0d cnt=%0d",
                           got.old_value, got.new_value, got.changed, got.status,
                           got.entry_count);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  n_mismatch++;
                  if (n_mismatch <= 10) begin
                     $display("ERROR: beat %0d mismatch", n_results);
                     $display("  expected old=%h new=%h chg=%b st=%0d cnt=%0d",
                              want.old_value, want.new_value, want.changed, want.status,
                              want.entry_count);
                     $display("  actual   old=%h new=%h chg=%b st=%0d cnt=%0d",
                              got.old_value, got.new_value, got.changed, got.status,
                              got.entry_count);
                  end
               end
            end
            stall_left = pick_wait(n_results);
            if (n_results == 400 || n_results == 1100) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [63:0]      k;
      logic [63:0]      x;
      kvtu_pkg::op_type op;
      int               phase;
      bit               drain;
      req_bus.valid   = 1'b0;
      req_bus.key     = '0;
      req_bus.op      = kvtu_pkg::OP_READ;
      req_bus.operand = '0;
      rsp_bus.ready   = 1'b0;
      reset           = 1'b1;
      for (int i = 0; i < CAPACITY; i++) tbl_used[i] = 1'b0;
      tbl_count = 0;

      // directed: zero key, absent key, wrap, erase, divide by zero, min/max edges
      add_req('0, kvtu_pkg::OP_SET, '1, 1'b0);
      add_req('1, kvtu_pkg::OP_READ, '0, 1'b0);
      add_req('1, kvtu_pkg::OP_SUB, 64'd5, 1'b0);
      add_req('1, kvtu_pkg::OP_SET, '1, 1'b0);
      add_req('1, kvtu_pkg::OP_SET, '1, 1'b0);
      add_req('1, kvtu_pkg::OP_ADD, 64'd1, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_ADD, 64'h8000_0000_0000_0000, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_MUL, 64'd2, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_MAX, 64'd3, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_MUL, '1, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_DIV, '0, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_DIV, 64'd7, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_MIN, 64'd1, 1'b0);
      add_req(64'd1, kvtu_pkg::OP_SUB, '1, 1'b0);
      add_req(64'h8000_0000_0000_0001, kvtu_pkg::OP_SET, 64'd10, 1'b0);
      add_req(64'h8000_0000_0000_0001, kvtu_pkg::OP_SUB, 64'd3, 1'b0);
      add_req(64'h8000_0000_0000_0001, kvtu_pkg::OP_MIN, '1, 1'b0);
      add_req(64'h8000_0000_0000_0001, kvtu_pkg::OP_MAX, '0, 1'b0);
      add_req(64'h8000_0000_0000_0001, kvtu_pkg::OP_READ, '1, 1'b0);
      add_req(64'h8000_0000_0000_0001, kvtu_pkg::OP_DIV, 64'd8, 1'b0);
      add_req('0, kvtu_pkg::OP_READ, '0, 1'b0);

      // key pool a little larger than the table so it fills and refuses inserts
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom, $urandom};
         if (key_pool[i] == '0) key_pool[i] = 64'(i + 2);
      end

      // phases cycle: grow (mostly inserts), churn (extra sub/div/min), mixed (any op)
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         phase = (n / PHASE_LEN) % 3;
         drain = (n == 0 || n == 500 || n == 1200);
         case ($urandom_range(0, 49))
            0: k = '0;
            1, 2: k = {$urandom, $urandom};
            default: k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         endcase
         x = pick_operand();
         if (phase == 0 && $urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 2))
               0: op = kvtu_pkg::OP_SET;
               1: op = kvtu_pkg::OP_ADD;
               default: op = kvtu_pkg::OP_MAX;
            endcase
            if (x == '0) x = 64'($urandom_range(1, 255));
         end else if (phase == 1 && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: op = kvtu_pkg::OP_SUB;
               1: op = kvtu_pkg::OP_DIV;
               default: op = kvtu_pkg::OP_MIN;
            endcase
         end else begin
            op = kvtu_pkg::op_type'($urandom_range(0, 7));
         end
         add_req(k, op, x, drain);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run: %0d requests, %0d responses, %0d mismatches", n_sent, n_results,
               n_mismatch);
      $display("Table: %0d inserts, %0d erases, %0d refused when full, %0d zero keys, peak %0d",
               n_inserts, n_erases, n_refused, n_zero_key, peak_count);
      if (n_mismatch == 0 && expected_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
